### hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store: transaction
// payloads, request and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // cell position and count compares; wide enough for the largest capacity
    localparam int IDX_W = 9;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [FOUND_W-1:0]  found_index;
        logic [COUNT_W-1:0]  count;
        logic                empty_res;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] count;
    } t_cell_cmd;

endpackage

### hdl/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top
// Bounded ordered list of words held in a row of cells, with insert, remove,
// get, set, search and clear requests, one result per request.
// ----------------------------------------------------------------------------
// Flow: an accepted request is held in the request register; its result is
// registered in the output register once that is free or being read, with
// no dependence on the list length. The next request is taken once the
// result is captured, while that result still waits on the output register.
// Reset: synchronous active-low; clears the count and both handshakes, the
// stored words stay undefined until written.
// ----------------------------------------------------------------------------
module positional_list_store_top #(
    parameter int CAPACITY   = pls_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = pls_pkg::DEF_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pls_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pls_pkg::t_out_item o_out_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IDX_W = pls_pkg::IDX_W;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    t_state                r_state;
    pls_pkg::t_in_item     r_req;
    logic [CW-1:0]         r_count;
    logic                  r_out_valid;
    pls_pkg::t_out_item    r_out;

    pls_pkg::t_out_item    n_out;
    logic [CW-1:0]         n_count;
    pls_pkg::t_cell_cmd    w_cmd;
    logic                  w_commit;

    logic [DATA_WIDTH-1:0] w_val;
    logic [DATA_WIDTH+pls_pkg::VALUE_W-1:0] w_val_wide;
    logic [DATA_WIDTH-1:0] w_word [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;
    logic [CAPACITY-1:0]   w_sel;
    logic [CAPACITY-1:0]   w_first;
    logic [DATA_WIDTH-1:0] w_sel_word;
    logic [DATA_WIDTH+pls_pkg::VALUE_W-1:0] w_sel_wide;
    logic [IDX_W-1:0]      w_found;
    logic [IDX_W-1:0]      w_pos_x;
    logic [IDX_W-1:0]      w_cnt_x;
    logic [CW+pls_pkg::COUNT_W-1:0] w_cnt_wide;

    localparam logic [IDX_W-1:0] CAP_X = IDX_W'(CAPACITY);

    // request word cut to the stored width
    assign w_val_wide = (DATA_WIDTH + pls_pkg::VALUE_W)'(r_req.value);
    assign w_val      = w_val_wide[DATA_WIDTH-1:0];
    assign w_pos_x    = IDX_W'(r_req.position);
    assign w_cnt_x    = IDX_W'(r_count);

    assign w_commit = (r_state == ST_BUSY) && (!r_out_valid || i_out_ready);

    // cell row
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = w_val;
        end else begin : g_mid_l
            assign w_left = w_word[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_word[k];
        end else begin : g_mid_r
            assign w_right = w_word[k+1];
        end
        pls_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_value (w_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[k]),
            .o_hit   (w_hit[k]),
            .o_sel   (w_sel[k])
        );
    end

    // lowest hit only, then one-hot to index
    assign w_first = w_hit & ~(w_hit - CAPACITY'(1));

    always_comb begin
        w_found    = '0;
        w_sel_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_first[k]) begin
                w_found = w_found | IDX_W'(k);
            end
            if (w_sel[k]) begin
                w_sel_word = w_sel_word | w_word[k];
            end
        end
    end

    assign w_sel_wide = (DATA_WIDTH + pls_pkg::VALUE_W)'(w_sel_word);

    always_comb begin
        n_count           = r_count;
        n_out.status      = pls_pkg::STATUS_OK;
        n_out.data        = '0;
        n_out.found_index = '0;
        w_cmd.op          = pls_pkg::CELL_HOLD;
        w_cmd.pos         = w_pos_x;
        w_cmd.count       = w_cnt_x;
        case (r_req.kind)
            pls_pkg::KIND_INSERT: begin
                if (w_pos_x > w_cnt_x) begin
                    n_out.status = pls_pkg::STATUS_RANGE;
                end else if (w_cnt_x >= CAP_X) begin
                    n_out.status = pls_pkg::STATUS_FULL;
                end else begin
                    w_cmd.op = pls_pkg::CELL_INSERT;
                    n_count  = r_count + CW'(1);
                end
            end
            pls_pkg::KIND_REMOVE: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_out.status = pls_pkg::STATUS_RANGE;
                end else begin
                    n_out.data = w_sel_wide[pls_pkg::VALUE_W-1:0];
                    w_cmd.op   = pls_pkg::CELL_REMOVE;
                    n_count    = r_count - CW'(1);
                end
            end
            pls_pkg::KIND_GET: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_out.status = pls_pkg::STATUS_RANGE;
                end else begin
                    n_out.data = w_sel_wide[pls_pkg::VALUE_W-1:0];
                end
            end
            pls_pkg::KIND_SET: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_out.status = pls_pkg::STATUS_RANGE;
                end else begin
                    w_cmd.op = pls_pkg::CELL_WRITE;
                end
            end
            pls_pkg::KIND_SEARCH: begin
                if (|w_hit) begin
                    n_out.found_index = w_found[pls_pkg::FOUND_W-1:0];
                end else begin
                    n_out.status = pls_pkg::STATUS_MISS;
                end
            end
            pls_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // cells only move when the result is captured
        if (!w_commit) begin
            w_cmd.op = pls_pkg::CELL_HOLD;
        end
        w_cnt_wide      = (CW + pls_pkg::COUNT_W)'(n_count);
        n_out.count     = w_cnt_wide[pls_pkg::COUNT_W-1:0];
        n_out.empty_res = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds a word, shifts from its left or right neighbor on
// insert and remove, and flags a position match and a search hit.
// ----------------------------------------------------------------------------
module pls_cell #(
    parameter int DATA_WIDTH = pls_pkg::DEF_DATA_WIDTH,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  pls_pkg::t_cell_cmd    i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic                  o_hit,
    output logic                  o_sel
);

    localparam logic [pls_pkg::IDX_W-1:0] K_IDX = pls_pkg::IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_cmd.op)
            pls_pkg::CELL_INSERT: begin
                if (K_IDX > i_cmd.pos) begin
                    n_word = i_left;
                end else if (K_IDX == i_cmd.pos) begin
                    n_word = i_value;
                end
            end
            pls_pkg::CELL_REMOVE: begin
                if (K_IDX >= i_cmd.pos) begin
                    n_word = i_right;
                end
            end
            pls_pkg::CELL_WRITE: begin
                if (K_IDX == i_cmd.pos) begin
                    n_word = i_value;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    // only slots below the count take part in a search
    assign o_hit  = (r_word == i_value) && (K_IDX < i_cmd.count);
    assign o_sel  = (K_IDX == i_cmd.pos);

endmodule
